### sv/pst_pkg.sv
// Package for the periodic soft timer bank.
// Holds the operation codes, field widths and the word types used by the other source files.
`default_nettype none

package pst_pkg;

   // Field widths of the request and response words.
   localparam int PERIOD_W    = 16;
   localparam int SLOT_ID_W   = 3;
   localparam int FIRE_MASK_W = 8;

   // Default size of the timer bank.
   localparam int SLOT_COUNT_DEFAULT = 8;

   // Operation codes carried by a request word.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_ADD   = 2'd1,
      OP_START = 2'd2,
      OP_STOP  = 2'd3
   } op_type;

   // One request word as it travels through the pipeline.
   typedef struct packed {
      op_type                 operation;
      logic [PERIOD_W-1:0]    period;
      logic [SLOT_ID_W-1:0]   slot_id;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [FIRE_MASK_W-1:0] fire_mask;
      logic [SLOT_ID_W-1:0]   assigned_slot;
      logic                   table_full;
   } rsp_type;

endpackage

`default_nettype wire

### sv/pst_channels.sv
// Valid/ready channel interfaces for the periodic soft timer bank.
// Depends on pst_pkg for the field widths.
`default_nettype none

// Request channel: one operation word per handshake.
interface pst_req_if;
   import pst_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           operation;
   logic [PERIOD_W-1:0]  period;
   logic [SLOT_ID_W-1:0] slot_id;

   modport source (output valid, output operation, output period, output slot_id,
                   input ready);
   modport sink   (input valid, input operation, input period, input slot_id,
                   output ready);
endinterface

// Response channel: one result word per request word.
interface pst_rsp_if;
   import pst_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FIRE_MASK_W-1:0] fire_mask;
   logic [SLOT_ID_W-1:0]   assigned_slot;
   logic                   table_full;

   modport source (output valid, output fire_mask, output assigned_slot,
                   output table_full, input ready);
   modport sink   (input valid, input fire_mask, input assigned_slot,
                   input table_full, output ready);
endinterface

`default_nettype wire

### sv/pst_slot_bank.sv
// Timer slot state and its combinational update for one request word.
// Depends on pst_pkg for the word types and operation codes.
`default_nettype none

module pst_slot_bank #(
   parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire pst_pkg::req_type req,
   output pst_pkg::rsp_type      rsp
);
   import pst_pkg::*;

   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int XW = CW + SLOT_ID_W;

   logic [CW-1:0]               used_ff;
   logic [CW-1:0]               used_in;
   logic [XW-1:0]               used_x;
   logic [XW-1:0]               id_x;
   logic                        has_room;
   logic                        is_add;
   logic [SLOT_COUNT-1:0]       fire;
   logic [SLOT_COUNT+FIRE_MASK_W-1:0] fire_x;

   // Compare slot numbers and the fill count at a common width.
   assign used_x   = XW'(used_ff);
   assign id_x     = XW'(req.slot_id);
   assign has_room = used_ff < CW'(SLOT_COUNT);
   assign is_add   = go && (req.operation == OP_ADD);

   // Fill count: an add that finds room takes the next slot.
   always_comb begin
      used_in = used_ff;
      if (is_add && has_room) begin
         used_in = used_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // One lane per slot: running mark, counter and period.
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
      localparam logic [XW-1:0] IDX = XW'(i);

      logic                run_ff;
      logic                run_in;
      logic [PERIOD_W-1:0] cnt_ff;
      logic [PERIOD_W-1:0] cnt_in;
      logic [PERIOD_W-1:0] per_ff;
      logic                registered;
      logic                add_here;
      logic                fire_s;

      assign registered = IDX < used_x;
      assign add_here   = is_add && has_room && (used_x == IDX);
      assign fire[i]    = fire_s;

      // Next state of the lane for the current operation.
      always_comb begin
         run_in = run_ff;
         cnt_in = cnt_ff;
         fire_s = 1'b0;
         if (go) begin
            case (req.operation)
               OP_TICK: begin
                  if (registered && run_ff) begin
                     if (cnt_ff < per_ff) begin
                        cnt_in = cnt_ff + PERIOD_W'(1);
                     end else begin
                        cnt_in = '0;
                        fire_s = 1'b1;
                     end
                  end
               end
               OP_ADD: begin
                  if (add_here) begin
                     run_in = 1'b0;
                     cnt_in = '0;
                  end
               end
               OP_START, OP_STOP: begin
                  if (registered && (id_x == IDX)) begin
                     run_in = (req.operation == OP_START);
                  end
               end
               default: begin
                  run_in = run_ff;
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            run_ff <= 1'b0;
            cnt_ff <= '0;
         end else begin
            run_ff <= run_in;
            cnt_ff <= cnt_in;
         end
      end

      // The period is only read once the slot is registered.
      always_ff @(posedge clock) begin
         if (add_here) begin
            per_ff <= req.period;
         end
      end
   end

   // Result word: only the low slots show in the mask.
   assign fire_x            = {{FIRE_MASK_W{1'b0}}, fire};
   assign rsp.fire_mask     = fire_x[FIRE_MASK_W-1:0];
   assign rsp.assigned_slot = (is_add && has_room) ? used_x[SLOT_ID_W-1:0] : '0;
   assign rsp.table_full    = is_add && !has_room;

endmodule

`default_nettype wire

### sv/periodic_soft_timer_bank.sv
// Periodic soft timer bank.
//
// The req channel takes one operation word per handshake: tick, add slot,
// start slot or stop slot. The rsp channel returns exactly one word for each
// request, in order: the fire mask of a tick, the slot number given by an add,
// or the full flag of an add that found no free slot.
//
// A request word is held in an input register; as it moves on, the slot lanes
// update in parallel and the result lands in an output register that drives rsp.
// While rsp does not stall, throughput is one word per cycle; both registers move
// on together, and the input register takes a new word while the output word is
// being taken. When rsp stalls, the output word holds, the input register keeps
// its word and req.ready drops once both are full; nothing is lost.
//
// Reset clears every running mark, every counter and the slot count, and
// empties both pipeline registers. No slot is registered after reset.
// Depends on pst_pkg, pst_channels and pst_slot_bank.
`default_nettype none

module periodic_soft_timer_bank #(
   parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   pst_req_if.sink   req,
   pst_rsp_if.source rsp
);
   import pst_pkg::*;

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_req_ff;
   logic    s1_fire;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type bank_rsp;
   logic    req_take;

   // Pipeline flow control.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_fire;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.operation <= op_type'(req.operation);
         s1_req_ff.period    <= req.period;
         s1_req_ff.slot_id   <= req.slot_id;
      end
   end

   // Slot lanes update when the word moves to the output register.
   pst_slot_bank #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_bank (
      .clock (clock),
      .reset (reset),
      .go    (s1_fire),
      .req   (s1_req_ff),
      .rsp   (bank_rsp)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= bank_rsp;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.fire_mask     = rsp_ff.fire_mask;
   assign rsp.assigned_slot = rsp_ff.assigned_slot;
   assign rsp.table_full    = rsp_ff.table_full;

   // An accepted word always sits in the input register next cycle.
   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request word did not reach the input register");

   // A word leaving the input register always shows up on rsp.
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp.valid)
      else $error("request word left the input register without a response");

   // A full answer carries no slot number and no fire bits.
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.table_full) |-> (rsp.assigned_slot == '0 && rsp.fire_mask == '0))
      else $error("full response carries a slot number or fire bits");

   // A non-add word never reports a full table.
   a_full_only_add: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_req_ff.operation != OP_ADD) |=> !rsp.table_full)
      else $error("full flag raised for an operation other than add");

endmodule

`default_nettype wire

### sim/periodic_soft_timer_bank_test.sv
// Self-checking testbench for the periodic soft timer bank.
// Drives operation words through pst_req_if, checks every response word against a
// local timer model. Depends on pst_pkg, pst_channels and periodic_soft_timer_bank.
`timescale 1ns / 1ps

module periodic_soft_timer_bank_test;
   import pst_pkg::*;

   localparam int BANK_SLOTS     = SLOT_COUNT_DEFAULT;
   localparam int RANDOM_WORDS   = 830;
   localparam int WORDS_PER_MODE = 96;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int SHOWN_ERRORS   = 10;

   // Back-pressure modes, stepped through as words are accepted.
   typedef enum logic [1:0] {
      MODE_STEADY      = 2'd0,
      MODE_SEND_GAPS   = 2'd1,
      MODE_RECV_STALLS = 2'd2,
      MODE_BOTH        = 2'd3
   } idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pst_req_if req_ch ();
   pst_rsp_if rsp_ch ();

   periodic_soft_timer_bank #(.SLOT_COUNT(BANK_SLOTS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Words waiting to be sent and responses still owed by the block.
   req_type op_queue[$];
   rsp_type timer_rsp_queue[$];

   // Local copy of the timer bank.
   logic        timer_on     [BANK_SLOTS];
   logic [15:0] timer_count  [BANK_SLOTS];
   logic [15:0] timer_period [BANK_SLOTS];
   int          slots_taken = 0;

   int      words_in    = 0;
   int      words_out   = 0;
   int      idle_cycles = 0;
   int      errors      = 0;
   int      tick_words  = 0;
   int      add_words   = 0;
   int      full_words  = 0;
   int      fire_words  = 0;
   req_type next_word;
   rsp_type got_word;
   rsp_type want_word;

   idle_mode_type idle_mode;
   assign idle_mode = idle_mode_type'((words_in / WORDS_PER_MODE) % 4);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one operation to the local bank and returns the response it owes.
   function automatic rsp_type apply_timer_op(req_type w);
      rsp_type r;
      r = '0;
      case (w.operation)
         OP_TICK: begin
            for (int i = 0; i < slots_taken; i++) begin
               if (timer_on[i]) begin
                  if (timer_count[i] < timer_period[i]) begin
                     timer_count[i] = timer_count[i] + 16'd1;
                  end else begin
                     timer_count[i] = '0;
                     if (i < FIRE_MASK_W) r.fire_mask[i] = 1'b1;
                  end
               end
            end
         end
         OP_ADD: begin
            if (slots_taken < BANK_SLOTS) begin
               timer_on[slots_taken]     = 1'b0;
               timer_count[slots_taken]  = '0;
               timer_period[slots_taken] = w.period;
               r.assigned_slot = SLOT_ID_W'(slots_taken);
               slots_taken++;
            end else begin
               r.table_full = 1'b1;
            end
         end
         default: begin
            // Start and stop of a slot that was never added change nothing.
            if (int'(w.slot_id) < slots_taken) timer_on[w.slot_id] = (w.operation == OP_START);
         end
      endcase
      return r;
   endfunction

   function automatic req_type make_word(op_type op, logic [15:0] period, logic [2:0] id);
      req_type w;
      w.operation = op;
      w.period    = period;
      w.slot_id   = id;
      return w;
   endfunction

   // Driver: presents the next queued word, with gaps when the mode calls for them.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (op_queue.size() != 0 &&
             !((idle_mode == MODE_SEND_GAPS && $urandom_range(99) < 52) ||
               (idle_mode == MODE_BOTH && $urandom_range(99) < 7))) begin
            next_word = op_queue.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.operation <= next_word.operation;
            req_ch.period    <= next_word.period;
            req_ch.slot_id   <= next_word.slot_id;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_ch.ready <= !((idle_mode == MODE_RECV_STALLS && $urandom_range(99) < 52) ||
                        (idle_mode == MODE_BOTH && $urandom_range(99) < 7));
   end

   // Monitor: checks responses first, then books the word accepted at this edge,
   // so a response is never matched against a word taken in the same cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_word = '{fire_mask: rsp_ch.fire_mask, assigned_slot: rsp_ch.assigned_slot,
                         table_full: rsp_ch.table_full};
            words_out <= words_out + 1;
            if (timer_rsp_queue.size() == 0) begin
               errors++;
               if (errors <= SHOWN_ERRORS)
                  $display("ERROR: unexpected response fire_mask=%h slot=%0d full=%b",
                           got_word.fire_mask, got_word.assigned_slot, got_word.table_full);
            end else begin
               want_word = timer_rsp_queue.pop_front();
               if (got_word.fire_mask !== want_word.fire_mask ||
                   got_word.assigned_slot !== want_word.assigned_slot ||
                   got_word.table_full !== want_word.table_full) begin
                  errors++;
                  if (errors <= SHOWN_ERRORS)
                     $display({"ERROR: response %0d: expected fire_mask=%h slot=%0d full=%b,",
                               " got fire_mask=%h slot=%0d full=%b"},
                              words_out, want_word.fire_mask, want_word.assigned_slot,
                              want_word.table_full, got_word.fire_mask,
                              got_word.assigned_slot, got_word.table_full);
               end
               if (want_word.fire_mask != '0) fire_words++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            words_in <= words_in + 1;
            if (req_ch.operation == OP_TICK) tick_words++;
            if (req_ch.operation == OP_ADD) add_words++;
            want_word = apply_timer_op(make_word(op_type'(req_ch.operation), req_ch.period,
                                                 req_ch.slot_id));
            if (want_word.table_full) full_words++;
            timer_rsp_queue.push_back(want_word);
         end
         // Watchdog on cycles with no word moving on either channel.
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus, end of run and verdict.
   initial begin
      int          pick;
      op_type      op;
      logic [15:0] period;

      for (int i = 0; i < BANK_SLOTS; i++) begin
         timer_on[i]     = 1'b0;
         timer_count[i]  = '0;
         timer_period[i] = '0;
      end
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_TICK;
      req_ch.period    = '0;
      req_ch.slot_id   = '0;
      rsp_ch.ready     = 1'b0;

      // Empty bank: a tick fires nothing, and start of slot 0 and stop of slot 7 are ignored.
      op_queue.push_back(make_word(OP_TICK, 16'hFFFF, 3'd7));
      op_queue.push_back(make_word(OP_START, 16'h0000, 3'd0));
      op_queue.push_back(make_word(OP_STOP, 16'hFFFF, 3'd7));
      // Fill the bank, with both period extremes, then one add too many.
      op_queue.push_back(make_word(OP_ADD, 16'h0000, 3'd5));
      op_queue.push_back(make_word(OP_START, 16'h0000, 3'd1));
      op_queue.push_back(make_word(OP_ADD, 16'hFFFF, 3'd0));
      op_queue.push_back(make_word(OP_ADD, 16'd1, 3'd0));
      op_queue.push_back(make_word(OP_ADD, 16'd2, 3'd0));
      op_queue.push_back(make_word(OP_ADD, 16'd3, 3'd0));
      op_queue.push_back(make_word(OP_ADD, 16'd0, 3'd0));
      op_queue.push_back(make_word(OP_ADD, 16'd4, 3'd0));
      op_queue.push_back(make_word(OP_ADD, 16'd5, 3'd0));
      op_queue.push_back(make_word(OP_ADD, 16'h1234, 3'd0));
      // Run a zero-period slot, the longest one and two short ones.
      op_queue.push_back(make_word(OP_TICK, 16'h0000, 3'd0));
      op_queue.push_back(make_word(OP_START, 16'h0000, 3'd0));
      op_queue.push_back(make_word(OP_START, 16'h0000, 3'd1));
      op_queue.push_back(make_word(OP_START, 16'h0000, 3'd2));
      op_queue.push_back(make_word(OP_START, 16'h0000, 3'd7));
      op_queue.push_back(make_word(OP_TICK, 16'h0000, 3'd0));
      op_queue.push_back(make_word(OP_TICK, 16'h0000, 3'd0));
      op_queue.push_back(make_word(OP_TICK, 16'h0000, 3'd0));
      op_queue.push_back(make_word(OP_STOP, 16'h0000, 3'd0));
      op_queue.push_back(make_word(OP_TICK, 16'h0000, 3'd0));

      // Random traffic: mostly ticks, with slots started and stopped at random.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick   = $urandom_range(99);
         period = 16'($urandom_range(65535));
         if (pick < 60) op = OP_TICK;
         else if (pick < 78) op = OP_START;
         else if (pick < 96) op = OP_STOP;
         else op = OP_ADD;
         op_queue.push_back(make_word(op, period, 3'($urandom_range(7))));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (op_queue.size() != 0 || req_ch.valid || timer_rsp_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d words: %0d ticks (%0d with slots firing), %0d adds (%0d refused),",
               words_in, tick_words, fire_words, add_words, full_words);
      $display("the rest start and stop, through four back-pressure modes; %0d errors.",
               errors);
      if (errors == 0 && timer_rsp_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### filelist.f
sv/pst_pkg.sv
sv/pst_channels.sv
sv/pst_slot_bank.sv
sv/periodic_soft_timer_bank.sv
sim/periodic_soft_timer_bank_test.sv
